### src/lil_pkg.sv
// Shared types and constants for the two-level learned index lookup.
// No dependencies.
`timescale 1ns / 1ps
package lil_pkg;

  typedef enum logic [1:0] {
    CMD_LOOKUP    = 2'd0,
    CMD_ROOT_WR   = 2'd1,
    CMD_HANDLE_WR = 2'd2,
    CMD_OFFSET_WR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_ROOT_BASE_KEY = 2'd0,
    REG_ROOT_SLOPE    = 2'd1,
    REG_ROOT_SIZE     = 2'd2,
    REG_HANDLE_TOTAL  = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT_PRED,
    S_ROOT_READ,
    S_HANDLE_READ,
    S_HANDLE_PRED,
    S_OFFSET_READ
  } back_state_e;

  typedef struct packed {
    cmd_e        command;
    logic [63:0] lookup_key;
    logic [63:0] slope_value;
    logic [15:0] entry_index;
    logic [31:0] entry_value;
    logic [15:0] table_base;
    logic [16:0] table_length;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  handle_index;
    logic [31:0] blk_offset;
    logic        used_next_handle;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    logic     index_ok;
  } front_item_t;

  typedef struct packed {
    logic [63:0] key_origin;
    logic [63:0] slope;
    logic [15:0] base;
    logic [16:0] length;
  } handle_t;

  typedef struct packed {
    logic        valid;
    front_item_t head;
  } front_head_t;

endpackage

### src/learned_index_two_level_lookup.sv
// Top level of the two-level learned index lookup: config registers, front, back,
// result queue. Depends on lil_pkg, lil_front, lil_back and lil_fifo.
//
//   channel   handshake               payload
//   items     push_i / full_o         in_data_i  (in_item_t)
//   results   pop_i / empty_o         out_data_o (out_item_t)
//   config    psel/penable/pwrite     paddr, pwdata, prdata (64-bit regs at 8*i)
//
// Table writes retire directly from the idle state of the back end. A lookup runs the
// iterative prediction unit once per model (one to three models), plus a registered
// RAM read at each table level that it visits.
// Items are carried out one at a time.
// Reset clears control state and the config registers; table contents are undefined until written.
// Input and result queues of two entries let either side stall on its own.
`timescale 1ns / 1ps
module learned_index_two_level_lookup import lil_pkg::*; #(
  parameter int ROOT_ENTRIES    = 1024,
  parameter int HANDLES         = 256,
  parameter int OFFSET_ENTRIES  = 65536,
  parameter int SLOPE_FRAC_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  in_item_t    in_data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        empty_o,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] root_base_key_q, root_slope_q;
  logic [10:0] root_size_q;
  logic [8:0]  handle_total_q;
  logic        cfg_wr;
  reg_e        reg_sel;

  front_head_t head;
  logic        front_pop, res_push, res_full;
  out_item_t   res;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_base_key_q <= '0;
      root_slope_q    <= '0;
      root_size_q     <= '0;
      handle_total_q  <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_ROOT_BASE_KEY: root_base_key_q <= pwdata;
        REG_ROOT_SLOPE:    root_slope_q    <= pwdata;
        REG_ROOT_SIZE:     root_size_q     <= pwdata[10:0];
        default:           handle_total_q  <= pwdata[8:0];
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ROOT_BASE_KEY: prdata = root_base_key_q;
      REG_ROOT_SLOPE:    prdata = root_slope_q;
      REG_ROOT_SIZE:     prdata = 64'(root_size_q);
      default:           prdata = 64'(handle_total_q);
    endcase
  end

  lil_front #(
    .ROOT_ENTRIES   (ROOT_ENTRIES),
    .HANDLES        (HANDLES),
    .OFFSET_ENTRIES (OFFSET_ENTRIES)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (in_data_i),
    .full_o (full_o),
    .pop_i  (front_pop),
    .head_o (head)
  );

  lil_back #(
    .ROOT_ENTRIES    (ROOT_ENTRIES),
    .HANDLES         (HANDLES),
    .OFFSET_ENTRIES  (OFFSET_ENTRIES),
    .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (front_pop),
    .root_base_key_i (root_base_key_q),
    .root_slope_i    (root_slope_q),
    .root_size_i     (root_size_q),
    .handle_total_i  (handle_total_q),
    .res_full_i      (res_full),
    .res_push_o      (res_push),
    .res_o           (res)
  );

  lil_fifo #(.T(out_item_t), .Depth(2)) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .empty_o (empty_o),
    .data_o  (out_data_o)
  );

endmodule

### src/lil_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module lil_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/lil_fifo.sv
// Small register queue used on both sides of the block.
// No dependencies.
`timescale 1ns / 1ps
module lil_fifo #(
  parameter type T     = logic,
  parameter int  Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output T     data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  T              mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

### src/lil_pred.sv
// Linear model prediction unit: ceil(slope * (key - first) / 2^F), saturated.
// 64x64 product built from four 32x32 partial products. Depends on nothing.
`timescale 1ns / 1ps
module lil_pred #(
  parameter int SLOPE_FRAC_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] key_i,
  input  logic [63:0] first_i,
  input  logic [63:0] slope_i,
  output logic        done_o,
  output logic [63:0] result_o
);

  localparam int F = SLOPE_FRAC_BITS;

  logic         busy_q;
  logic [2:0]   step_q;
  logic [63:0]  diff_q, slope_q;
  logic [63:0]  pp_q;
  logic [1:0]   sh_q;
  logic [127:0] acc_q;
  logic         done_q;
  logic [63:0]  res_q;

  logic [31:0]  a_sel, b_sel;
  logic [127:0] pp_shift;
  logic         frac_nz, hi_nz;
  logic [63:0]  q_lo, fin;

  assign a_sel = step_q[1] ? diff_q[63:32] : diff_q[31:0];
  assign b_sel = step_q[0] ? slope_q[63:32] : slope_q[31:0];

  always_comb begin
    case (sh_q)
      2'd0:    pp_shift = {64'd0, pp_q};
      2'd1:    pp_shift = {32'd0, pp_q, 32'd0};
      default: pp_shift = {pp_q, 64'd0};
    endcase
  end

  assign frac_nz = |acc_q[F-1:0];
  assign hi_nz   = |acc_q[127:64+F];
  assign q_lo    = acc_q[63+F:F];
  assign fin     = hi_nz ? '1 : (frac_nz ? ((&q_lo) ? '1 : q_lo + 64'd1) : q_lo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == 3'd5) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      diff_q  <= key_i - first_i;
      slope_q <= slope_i;
      acc_q   <= '0;
    end else if (busy_q) begin
      if (step_q <= 3'd3) begin
        pp_q <= a_sel * b_sel;
        sh_q <= {1'b0, step_q[1]} + {1'b0, step_q[0]};
      end
      if (step_q >= 3'd1 && step_q <= 3'd4) begin
        acc_q <= acc_q + pp_shift;
      end
      if (step_q == 3'd5) begin
        res_q <= fin;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

### src/lil_front.sv
// Front end: accepts items, checks write indexes against table sizes, queues them.
// Depends on lil_pkg and lil_fifo.
`timescale 1ns / 1ps
module lil_front import lil_pkg::*; #(
  parameter int ROOT_ENTRIES   = 1024,
  parameter int HANDLES        = 256,
  parameter int OFFSET_ENTRIES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  in_item_t    data_i,
  output logic        full_o,
  input  logic        pop_i,
  output front_head_t head_o
);

  localparam logic [24:0] RootLim   = 25'(ROOT_ENTRIES);
  localparam logic [24:0] HandleLim = 25'(HANDLES);
  localparam logic [24:0] OffLim    = 25'(OFFSET_ENTRIES);

  front_item_t cls;
  logic [24:0] idx_x;
  logic        empty;

  assign idx_x = 25'(data_i.entry_index);

  always_comb begin
    cls.item = data_i;
    case (data_i.command)
      CMD_ROOT_WR:   cls.index_ok = idx_x < RootLim;
      CMD_HANDLE_WR: cls.index_ok = idx_x < HandleLim;
      CMD_OFFSET_WR: cls.index_ok = idx_x < OffLim;
      default:       cls.index_ok = 1'b1;
    endcase
  end

  lil_fifo #(.T(front_item_t), .Depth(2)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cls),
    .full_o  (full_o),
    .pop_i   (pop_i),
    .empty_o (empty),
    .data_o  (head_o.head)
  );

  assign head_o.valid = !empty;

endmodule

### src/lil_back.sv
// Back end: carries out table writes and lookups over the table RAMs.
// Depends on lil_pkg, lil_ram and lil_pred.
`timescale 1ns / 1ps
module lil_back import lil_pkg::*; #(
  parameter int ROOT_ENTRIES    = 1024,
  parameter int HANDLES         = 256,
  parameter int OFFSET_ENTRIES  = 65536,
  parameter int SLOPE_FRAC_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  front_head_t head_i,
  output logic        pop_o,
  input  logic [63:0] root_base_key_i,
  input  logic [63:0] root_slope_i,
  input  logic [10:0] root_size_i,
  input  logic [8:0]  handle_total_i,
  input  logic        res_full_i,
  output logic        res_push_o,
  output out_item_t   res_o
);

  localparam int RA = $clog2(ROOT_ENTRIES);
  localparam int HA = $clog2(HANDLES);
  localparam int OA = $clog2(OFFSET_ENTRIES);
  localparam logic [16:0] RootLim   = 17'(ROOT_ENTRIES);
  localparam logic [16:0] HandleLim = 17'(HANDLES);
  localparam logic [24:0] OffLim    = 25'(OFFSET_ENTRIES);

  back_state_e state_q, state_d;
  logic [63:0] key_q, key_d;
  logic [8:0]  h_q, h_d;
  logic        next_q, next_d;
  logic [15:0] base_q, base_d;
  logic [16:0] len_q, len_d;

  in_item_t    it;
  logic [16:0] lim_root, lim_h, size_x, total_x;
  logic        mul_start, mul_done;
  logic [63:0] mul_key, mul_first, mul_slope, mul_res;

  logic           root_we, handle_we, off_we;
  logic [7:0]     root_rdata;
  handle_t        handle_wdata, handle_rdata;
  logic [31:0]    off_rdata;
  logic [24:0]    eidx_x, off_addr_x;
  logic [16:0]    hc_x, hn_x, hr_x;
  logic [8:0]     h_cand, h_next;
  logic           cand_ok, next_ok, p_ok, idx_ok;
  logic [17:0]    off_addr;

  assign it      = head_i.head.item;
  assign size_x  = 17'(root_size_i);
  assign total_x = 17'(handle_total_i);
  assign lim_root = (size_x < RootLim) ? size_x : RootLim;
  assign lim_h    = (total_x < HandleLim) ? total_x : HandleLim;

  assign h_cand  = (state_q == S_ROOT_READ) ? {1'b0, root_rdata} : '0;
  assign hc_x    = 17'(h_cand);
  assign cand_ok = hc_x < lim_h;
  assign h_next  = h_q + 9'd1;
  assign hn_x    = 17'(h_next);
  assign next_ok = !next_q && (hn_x < lim_h);
  assign hr_x    = (state_q == S_HANDLE_PRED || state_q == S_OFFSET_READ) ? hn_x : hc_x;

  assign p_ok     = (mul_res[63:17] == '0) && (mul_res[16:0] < lim_root);
  assign off_addr = 18'(base_q) + 18'(mul_res[16:0]);
  assign off_addr_x = 25'(off_addr);
  assign idx_ok   = (mul_res[63:17] == '0) && (mul_res[16:0] < len_q) &&
                    (off_addr_x < OffLim);
  assign eidx_x   = 25'(it.entry_index);

  assign handle_wdata.key_origin = it.lookup_key;
  assign handle_wdata.slope      = it.slope_value;
  assign handle_wdata.base       = it.table_base;
  assign handle_wdata.length     = it.table_length;

  always_comb begin
    state_d    = state_q;
    key_d      = key_q;
    h_d        = h_q;
    next_d     = next_q;
    base_d     = base_q;
    len_d      = len_q;
    pop_o      = 1'b0;
    root_we    = 1'b0;
    handle_we  = 1'b0;
    off_we     = 1'b0;
    mul_start  = 1'b0;
    mul_key    = it.lookup_key;
    mul_first  = root_base_key_i;
    mul_slope  = root_slope_i;
    res_push_o = 1'b0;
    res_o      = '0;
    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          case (it.command)
            CMD_LOOKUP: begin
              if (!res_full_i) begin
                pop_o     = 1'b1;
                key_d     = it.lookup_key;
                h_d       = '0;
                next_d    = 1'b0;
                mul_start = 1'b1;
                state_d   = S_ROOT_PRED;
              end
            end
            CMD_ROOT_WR: begin
              pop_o   = 1'b1;
              root_we = head_i.head.index_ok;
            end
            CMD_HANDLE_WR: begin
              pop_o     = 1'b1;
              handle_we = head_i.head.index_ok;
            end
            default: begin
              pop_o  = 1'b1;
              off_we = head_i.head.index_ok;
            end
          endcase
        end
      end
      S_ROOT_PRED: begin
        if (mul_done) begin
          if (!p_ok) begin
            res_push_o = 1'b1;
            state_d    = S_IDLE;
          end else if (mul_res != '0) begin
            state_d = S_ROOT_READ;
          end else if (cand_ok) begin
            h_d     = h_cand;
            state_d = S_HANDLE_READ;
          end else begin
            res_push_o = 1'b1;
            state_d    = S_IDLE;
          end
        end
      end
      S_ROOT_READ: begin
        if (cand_ok) begin
          h_d     = h_cand;
          state_d = S_HANDLE_READ;
        end else begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_HANDLE_READ: begin
        base_d    = handle_rdata.base;
        len_d     = handle_rdata.length;
        mul_key   = key_q;
        mul_first = handle_rdata.key_origin;
        mul_slope = handle_rdata.slope;
        mul_start = 1'b1;
        state_d   = S_HANDLE_PRED;
      end
      S_HANDLE_PRED: begin
        if (mul_done) begin
          if (idx_ok) begin
            state_d = S_OFFSET_READ;
          end else if (next_ok) begin
            next_d  = 1'b1;
            h_d     = h_next;
            state_d = S_HANDLE_READ;
          end else begin
            res_push_o = 1'b1;
            res_o.used_next_handle = next_q;
            state_d    = S_IDLE;
          end
        end
      end
      S_OFFSET_READ: begin
        if (off_rdata != '1) begin
          res_push_o = 1'b1;
          res_o.found            = 1'b1;
          res_o.handle_index     = h_q[7:0];
          res_o.blk_offset       = off_rdata;
          res_o.used_next_handle = next_q;
          state_d    = S_IDLE;
        end else if (next_ok) begin
          next_d  = 1'b1;
          h_d     = h_next;
          state_d = S_HANDLE_READ;
        end else begin
          res_push_o = 1'b1;
          res_o.used_next_handle = next_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      next_q  <= 1'b0;
      h_q     <= '0;
    end else begin
      state_q <= state_d;
      next_q  <= next_d;
      h_q     <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    base_q <= base_d;
    len_q  <= len_d;
  end

  lil_pred #(.SLOPE_FRAC_BITS(SLOPE_FRAC_BITS)) u_pred (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .key_i    (mul_key),
    .first_i  (mul_first),
    .slope_i  (mul_slope),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

  lil_ram #(.Width(8), .Depth(ROOT_ENTRIES)) u_root_ram (
    .clk_i   (clk_i),
    .we_i    (root_we),
    .waddr_i (eidx_x[RA-1:0]),
    .wdata_i (it.entry_value[7:0]),
    .raddr_i (mul_res[RA-1:0]),
    .rdata_o (root_rdata)
  );

  lil_ram #(.Width($bits(handle_t)), .Depth(HANDLES)) u_handle_ram (
    .clk_i   (clk_i),
    .we_i    (handle_we),
    .waddr_i (eidx_x[HA-1:0]),
    .wdata_i (handle_wdata),
    .raddr_i (hr_x[HA-1:0]),
    .rdata_o (handle_rdata)
  );

  lil_ram #(.Width(32), .Depth(OFFSET_ENTRIES)) u_offset_ram (
    .clk_i   (clk_i),
    .we_i    (off_we),
    .waddr_i (eidx_x[OA-1:0]),
    .wdata_i (it.entry_value),
    .raddr_i (off_addr_x[OA-1:0]),
    .rdata_o (off_rdata)
  );

endmodule
